[src/crt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pkg: shared definitions for the call/return tracer
// Sizes, request codes and the structs that travel between the tracer's
// modules.
// ----------------------------------------------------------------------------
package crt_pkg;

  // The 8-bit entry_index field limits the symbol table to 256 entries.
  localparam int unsigned TBL_ENTRIES = 256;
  localparam int unsigned STK_ENTRIES = 64;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned TBL_IDX_W = 8;
  localparam int unsigned SYM_CNT_W = 9;
  localparam int unsigned DEPTH_W   = 10;
  localparam int unsigned STK_CNT_W = $clog2(STK_ENTRIES + 1);
  localparam int unsigned STK_IDX_W = (STK_ENTRIES > 1) ? $clog2(STK_ENTRIES) : 1;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX  = '1;
  localparam logic [ADDR_W-1:0]  RET_OFFSET = 32'd4;

  localparam logic EVT_CALL = 1'b0;
  localparam logic EVT_RET  = 1'b1;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_CALL = 2'd1,
    REQ_RET  = 2'd2
  } req_type_e;

  // A lookup request moving down the cell chain.
  typedef struct packed {
    logic                 valid;
    logic [ADDR_W-1:0]    addr;
    logic                 found;
    logic [TBL_IDX_W-1:0] idx;
  } query_t;

  // A table entry write broadcast to the cells.
  typedef struct packed {
    logic                 we;
    logic [TBL_IDX_W-1:0] idx;
    logic [ADDR_W-1:0]    start;
    logic [ADDR_W-1:0]    size;
  } load_t;

endpackage

[src/crt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_cell: one symbol table entry
// Holds one address range and checks the lookup passing through it.
// ----------------------------------------------------------------------------
module crt_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  logic                            wr_i,
  input  logic [crt_pkg::ADDR_W-1:0]      lo_i,
  input  logic [crt_pkg::ADDR_W-1:0]      hi_i,
  input  logic                            use_i,
  input  logic [crt_pkg::TBL_IDX_W-1:0]   cell_idx_i,
  input  crt_pkg::query_t                 q_i,
  output crt_pkg::query_t                 q_o
);
  import crt_pkg::*;

  logic [ADDR_W-1:0] lo_q, hi_q;
  query_t            q_d, q_q;
  logic              hit;

  // The range end is stored already summed, modulo 2^32.
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      lo_q <= lo_i;
      hi_q <= hi_i;
    end
  end

  assign hit = (q_i.addr >= lo_q) && (q_i.addr < hi_q);

  // The first in-use entry that matches claims the lookup.
  always_comb begin
    q_d = q_i;
    if (q_i.valid && !q_i.found && use_i && hit) begin
      q_d.found = 1'b1;
      q_d.idx   = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else if (advance_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

[src/crt_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_chain: row of symbol table cells
// A lookup enters at cell zero and moves one cell per cycle while advance_i is high.
// ----------------------------------------------------------------------------
module crt_chain (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  crt_pkg::load_t                  load_i,
  input  logic [crt_pkg::SYM_CNT_W-1:0]   symbol_count_i,
  input  crt_pkg::query_t                 q_i,
  output crt_pkg::query_t                 q_o
);
  import crt_pkg::*;

  query_t            link [TBL_ENTRIES+1];
  logic [ADDR_W-1:0] load_hi;

  // One adder for the range end, shared by every cell.
  assign load_hi = load_i.start + load_i.size;
  assign link[0] = q_i;

  for (genvar i = 0; i < TBL_ENTRIES; i++) begin : g_cell
    logic wr, in_use;

    assign wr     = load_i.we && (load_i.idx == TBL_IDX_W'(i));
    assign in_use = SYM_CNT_W'(i) < symbol_count_i;

    crt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .advance_i  (advance_i),
      .wr_i       (wr),
      .lo_i       (load_i.start),
      .hi_i       (load_hi),
      .use_i      (in_use),
      .cell_idx_i (TBL_IDX_W'(i)),
      .q_i        (link[i]),
      .q_o        (link[i+1])
    );
  end

  assign q_o = link[TBL_ENTRIES];

endmodule

[src/call_return_trace_with_symbol_lookup.sv]
`timescale 1ns / 1ps
// A call or return beat is registered into the first lookup cell on acceptance,
// moves through every lookup cell register in turn while the chain advances,
// then into the output register, where its record is presented.
// A new call or return is taken only once the record of the last has moved into
// the output register; load beats and beats that produce no record do not block.
// Reset clears the nesting depth, the stack count and symbol_count; table and
// return stack contents are undefined until written.
// ----------------------------------------------------------------------------
// call_return_trace_with_symbol_lookup: call/return tracer
// Keeps a bounded return stack and nesting depth, and searches a table of
// symbol ranges for the target of each call and the pc of each return.
// ----------------------------------------------------------------------------
module call_return_trace_with_symbol_lookup (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration: symbol_count register.
  input  logic                            cfg_we_i,
  input  logic [crt_pkg::SYM_CNT_W-1:0]   cfg_wdata_i,
  // Request channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      req_type_i,
  input  logic [crt_pkg::ADDR_W-1:0]      pc_i,
  input  logic [crt_pkg::ADDR_W-1:0]      target_i,
  input  logic [crt_pkg::TBL_IDX_W-1:0]   entry_index_i,
  input  logic [crt_pkg::ADDR_W-1:0]      entry_start_i,
  input  logic [crt_pkg::ADDR_W-1:0]      entry_size_i,
  // Trace record channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            event_kind_o,
  output logic [crt_pkg::ADDR_W-1:0]      event_pc_o,
  output logic [crt_pkg::ADDR_W-1:0]      looked_up_addr_o,
  output logic [crt_pkg::DEPTH_W-1:0]     indent_depth_o,
  output logic                            symbol_found_o,
  output logic [crt_pkg::TBL_IDX_W-1:0]   symbol_index_o,
  output logic [crt_pkg::ADDR_W-1:0]      return_addr_o,
  output logic                            stack_full_o
);
  import crt_pkg::*;

  // Control state.
  logic                 busy_q;
  logic                 out_valid_q;
  logic [SYM_CNT_W-1:0] symbol_count_q;
  logic [STK_CNT_W-1:0] stk_cnt_q;
  logic [DEPTH_W-1:0]   nest_q;

  // Details of the record in flight, captured when its beat is accepted.
  logic                 info_kind_q;
  logic [ADDR_W-1:0]    info_pc_q;
  logic [DEPTH_W-1:0]   info_depth_q;
  logic [ADDR_W-1:0]    info_ret_q;
  logic                 info_full_q;
  logic [ADDR_W-1:0]    pop_q;

  // Return stack memory.
  logic [ADDR_W-1:0]    stk_mem [STK_ENTRIES];

  logic                 accept;
  logic                 do_load, do_call, do_ret;
  logic                 issue, push, room;
  logic [ADDR_W-1:0]    ret_addr;
  logic [DEPTH_W-1:0]   nest_dec;
  logic [STK_CNT_W-1:0] stk_cnt_dec;
  load_t                load;
  query_t               q_in, q_out;
  logic                 out_load, advance;

  assign accept     = in_valid_i && in_ready_o;
  // Only one call or return is in flight; the next waits until its record
  // has moved into the output register.
  assign in_ready_o = !busy_q;

  always_comb begin
    do_load = 1'b0;
    do_call = 1'b0;
    do_ret  = 1'b0;
    case (req_type_e'(req_type_i))
      REQ_LOAD: do_load = accept;
      REQ_CALL: do_call = accept;
      REQ_RET:  do_ret  = accept && (stk_cnt_q != '0);
      default: ;
    endcase
  end

  assign room        = stk_cnt_q < STK_CNT_W'(STK_ENTRIES);
  assign push        = do_call && room;
  assign issue       = do_call || do_ret;
  assign ret_addr    = pc_i + RET_OFFSET;
  assign nest_dec    = (nest_q != '0) ? nest_q - DEPTH_W'(1) : nest_q;
  assign stk_cnt_dec = stk_cnt_q - STK_CNT_W'(1);

  // Loads are broadcast to the cells; each index writes exactly one cell.
  assign load.we    = do_load;
  assign load.idx   = entry_index_i;
  assign load.start = entry_start_i;
  assign load.size  = entry_size_i;

  // The lookup address is the call target, or the pc of a return.
  assign q_in.valid = issue;
  assign q_in.addr  = do_call ? target_i : pc_i;
  assign q_in.found = 1'b0;
  assign q_in.idx   = '0;

  // The chain end holds its result while the output register is occupied.
  assign out_load = q_out.valid && (!out_valid_q || out_ready_i);
  assign advance  = !q_out.valid || out_load;

  crt_chain u_chain (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .load_i         (load),
    .symbol_count_i (symbol_count_q),
    .q_i            (q_in),
    .q_o            (q_out)
  );

  // Return stack: push on a call with room, pop on a return to a non-empty
  // stack. The popped word is registered and waits for the lookup.
  always_ff @(posedge clk_i) begin
    if (push) begin
      stk_mem[stk_cnt_q[STK_IDX_W-1:0]] <= ret_addr;
    end
    if (do_ret) begin
      pop_q <= stk_mem[stk_cnt_dec[STK_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      info_kind_q  <= do_ret ? EVT_RET : EVT_CALL;
      info_pc_q    <= pc_i;
      info_depth_q <= do_ret ? nest_dec : nest_q;
      info_ret_q   <= ret_addr;
      info_full_q  <= do_call && !room;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      symbol_count_q <= '0;
      stk_cnt_q      <= '0;
      nest_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        symbol_count_q <= cfg_wdata_i;
      end
      if (issue) begin
        busy_q <= 1'b1;
      end else if (out_load) begin
        busy_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (push) begin
        stk_cnt_q <= stk_cnt_q + STK_CNT_W'(1);
      end else if (do_ret) begin
        stk_cnt_q <= stk_cnt_dec;
      end
      // The depth saturates at both ends.
      if (do_call && (nest_q != DEPTH_MAX)) begin
        nest_q <= nest_q + DEPTH_W'(1);
      end else if (do_ret) begin
        nest_q <= nest_dec;
      end
    end
  end

  // Output register: the record waits here while the next beat is taken.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      event_kind_o     <= info_kind_q;
      event_pc_o       <= info_pc_q;
      looked_up_addr_o <= q_out.addr;
      indent_depth_o   <= info_depth_q;
      symbol_found_o   <= q_out.found;
      symbol_index_o   <= q_out.idx;
      return_addr_o    <= (info_kind_q == EVT_RET) ? pop_q : info_ret_q;
      stack_full_o     <= info_full_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[src/crt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_checker: port checks for the call/return tracer
// Watches the record channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
module crt_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic                            event_kind_i,
  input logic [crt_pkg::ADDR_W-1:0]      event_pc_i,
  input logic                            symbol_found_i,
  input logic [crt_pkg::TBL_IDX_W-1:0]   symbol_index_i,
  input logic [crt_pkg::ADDR_W-1:0]      return_addr_i,
  input logic                            stack_full_i
);
  import crt_pkg::*;

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("record beat dropped before it was taken");

  a_pc_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(event_pc_i))
    else $error("stalled record beat changed");

  a_miss_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !symbol_found_i |-> symbol_index_i == '0)
    else $error("missed lookup reports a nonzero index");

  a_ret_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == EVT_RET) |-> !stack_full_i)
    else $error("return record flags a full stack");

  a_call_ret_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == EVT_CALL) |-> return_addr_i == event_pc_i + RET_OFFSET)
    else $error("call record return address is not pc plus four");

endmodule

bind call_return_trace_with_symbol_lookup crt_checker u_crt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .event_kind_i   (event_kind_o),
  .event_pc_i     (event_pc_o),
  .symbol_found_i (symbol_found_o),
  .symbol_index_i (symbol_index_o),
  .return_addr_i  (return_addr_o),
  .stack_full_i   (stack_full_o)
);
